@@ rtl/m2ts_pkg.sv @@
// Shared constants, types and state codes for the M2TS arrival stamp interpolator.
package m2ts_pkg;

	// Field widths
	localparam int unsigned PCR_W   = 42;
	localparam int unsigned STAMP_W = 30;
	localparam int unsigned CNT_W   = 7;
	localparam int unsigned IDX_W   = 6;
	localparam int unsigned OFF_W   = 15;
	localparam int unsigned BYTE_W  = 14;
	localparam int unsigned DIFF_W  = 16;
	localparam int unsigned PROD_W  = PCR_W + BYTE_W;

	// Stamped packet length in bytes
	localparam int unsigned PACKET_BYTES = 192;

	// Serial multiply/divide schedule
	localparam int unsigned MUL_STEPS  = BYTE_W;
	localparam int unsigned DIV_STEPS  = PROD_W;
	localparam int unsigned TOTAL_STEPS = MUL_STEPS + DIV_STEPS;
	localparam int unsigned STEP_W     = $clog2(TOTAL_STEPS);

	// Reference position of a packet that just took the reference
	localparam logic signed [OFF_W-1:0] OFF_AFTER_CUR = -(OFF_W'(PACKET_BYTES));

	// Operation codes
	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_DRAIN  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_EMIT,
		ST_SINGLE
	} m2ts_state_t;

	typedef struct packed {
		logic [STAMP_W-1:0] arrival_stamp;
		logic               stamp_valid;
		logic               is_current_packet;
		logic               overflow;
		logic               last_of_run;
	} m2ts_result_t;

endpackage

@@ rtl/m2ts_in_if.sv @@
// Packet event channel: valid/ready plus the event payload.
interface m2ts_in_if import m2ts_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             operation;
	logic             pcr_present;
	logic [PCR_W-1:0] pcr_value;

	modport source(output valid, output operation, output pcr_present, output pcr_value,
		input ready);
	modport sink(input valid, input operation, input pcr_present, input pcr_value,
		output ready);
endinterface

@@ rtl/m2ts_out_if.sv @@
// Result channel: valid/ready plus one stamp result.
interface m2ts_out_if import m2ts_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [STAMP_W-1:0] arrival_stamp;
	logic               stamp_valid;
	logic               is_current_packet;
	logic               overflow;
	logic               last_of_run;

	modport source(output valid, output arrival_stamp, output stamp_valid,
		output is_current_packet, output overflow, output last_of_run, input ready);
	modport sink(input valid, input arrival_stamp, input stamp_valid,
		input is_current_packet, input overflow, input last_of_run, output ready);
endinterface

@@ rtl/m2ts_arrival_stamp_interpolator.sv @@
// Top level: PCR tracking, pending count and flush sequencer for M2TS arrival stamps.
//
//   channel   dir   handshake            beat contents
//   packet    in    valid/ready          operation, pcr_present, pcr_value
//   result    out   valid/ready          arrival_stamp, stamp_valid, is_current_packet,
//                                        overflow, last_of_run
//   cfg       in    cfg_wr_en            cfg_wr_data -> stamp_mode_enable
//
// One event at a time. Each flushed pending packet passes through start, then the
// 14 multiply and 56 divide steps of the serial unit, then done and emit.
// arst_n clears all control and tracking state; mode resets to pass-through.
// A stalled result channel holds the sequencer in its emit or single state; the output register
// lets the next event be taken while the final beat still waits.
module m2ts_arrival_stamp_interpolator import m2ts_pkg::*; #(
	parameter int unsigned PENDING_DEPTH = 63
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	m2ts_in_if.sink    packet,
	m2ts_out_if.source result
);

	m2ts_state_t state_q, state_d;

	logic                     mode_q;
	logic                     have_ref_q;
	logic [PCR_W-1:0]         ref_pcr_q;
	logic signed [OFF_W-1:0]  ref_off_q;
	logic [PCR_W-1:0]         rate_ticks_q;
	logic [BYTE_W-1:0]        rate_bytes_q;
	logic [CNT_W-1:0]         pend_q;
	logic [IDX_W-1:0]         idx_q;
	logic [BYTE_W-1:0]        pos_q;
	logic                     neg_q;
	logic                     tail_q;
	logic                     upd_ref_q;
	logic [PCR_W-1:0]         cur_pcr_q;
	m2ts_result_t             single_q;

	logic                     accept;
	logic                     is_drain;
	logic                     drain_flush;
	logic                     pass_thru;
	logic                     hold_path;
	logic                     pend_full;
	logic                     pcr_path;
	logic                     pcr_flush;
	logic                     pcr_same;
	logic [BYTE_W-1:0]        pend_bytes;
	logic signed [DIFF_W-1:0] byte_span;
	logic                     dist_pos;
	logic signed [DIFF_W-1:0] fdiff;
	logic [DIFF_W-1:0]        fmag;
	logic                     fneg;
	logic                     last_beat;
	logic [STAMP_W-1:0]       flush_stamp;

	logic                     div_start;
	logic                     div_done;
	logic [STAMP_W-1:0]       div_quo;
	logic                     load_valid;
	logic                     load_ready;
	m2ts_result_t             load_data;

	// Event decode
	assign accept      = packet.valid && packet.ready;
	assign is_drain    = packet.operation == OP_DRAIN;
	assign pcr_same    = packet.pcr_value == ref_pcr_q;
	assign pend_full   = pend_q >= CNT_W'(PENDING_DEPTH);
	assign drain_flush = is_drain && have_ref_q && (pend_q != '0);
	assign pass_thru   = !is_drain && !mode_q;
	assign hold_path   = !is_drain && mode_q
		&& (!packet.pcr_present || (!have_ref_q && (pend_q != '0)));
	assign pcr_path    = !is_drain && mode_q && !hold_path;
	assign pcr_flush   = pcr_path && (pend_q != '0) && !pcr_same;

	// Byte distance from the reference to the arriving packet
	assign pend_bytes = (BYTE_W'(pend_q) << 7) + (BYTE_W'(pend_q) << 6);
	assign byte_span  = $signed({2'b00, pend_bytes}) - DIFF_W'(ref_off_q);
	assign dist_pos   = !byte_span[DIFF_W-1] && (byte_span != '0);

	// Distance of the pending packet under flush from the reference
	assign fdiff = $signed({2'b00, pos_q}) - DIFF_W'(ref_off_q);
	assign fneg  = fdiff[DIFF_W-1];
	assign fmag  = fneg ? DIFF_W'(-fdiff) : DIFF_W'(fdiff);

	assign last_beat   = (CNT_W'(idx_q) + CNT_W'(1)) == pend_q;
	assign flush_stamp = neg_q ? (ref_pcr_q[STAMP_W-1:0] - div_quo)
		: (ref_pcr_q[STAMP_W-1:0] + div_quo);

	// Interpolation unit
	m2ts_serial_muldiv u_muldiv (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.span       (fmag[BYTE_W-1:0]),
		.rate_ticks (rate_ticks_q),
		.rate_bytes (rate_bytes_q),
		.done       (div_done),
		.quotient   (div_quo)
	);

	// Output register
	m2ts_result_reg u_result_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (load_valid),
		.load_data  (load_data),
		.load_ready (load_ready),
		.result     (result)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and sequencer outputs
	always_comb begin
		state_d      = state_q;
		packet.ready = 1'b0;
		div_start    = 1'b0;
		load_valid   = 1'b0;
		load_data    = single_q;
		unique case (state_q)
			ST_IDLE: begin
				packet.ready = 1'b1;
				if (accept) begin
					if (drain_flush || pcr_flush) begin
						state_d = ST_START;
					end else if (pass_thru || (hold_path && pend_full) || pcr_path) begin
						state_d = ST_SINGLE;
					end
				end
			end
			ST_START: begin
				div_start = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				if (div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				load_valid                  = 1'b1;
				load_data.arrival_stamp     = flush_stamp;
				load_data.stamp_valid       = 1'b1;
				load_data.is_current_packet = 1'b0;
				load_data.overflow          = 1'b0;
				load_data.last_of_run       = last_beat && !tail_q;
				if (load_ready) begin
					if (!last_beat) begin
						state_d = ST_START;
					end else if (tail_q) begin
						state_d = ST_SINGLE;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_SINGLE: begin
				load_valid = 1'b1;
				if (load_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	// Reference, rate and pending tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_ref_q   <= 1'b0;
			ref_pcr_q    <= '0;
			ref_off_q    <= '0;
			rate_ticks_q <= PCR_W'(1);
			rate_bytes_q <= BYTE_W'(1);
			pend_q       <= '0;
			idx_q        <= '0;
			pos_q        <= '0;
			tail_q       <= 1'b0;
			upd_ref_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q     <= '0;
						pos_q     <= '0;
						tail_q    <= pcr_flush;
						upd_ref_q <= pcr_path && (!have_ref_q || !pcr_same);
						if (hold_path && !pend_full) begin
							pend_q <= pend_q + CNT_W'(1);
							if (packet.pcr_present) begin
								have_ref_q <= 1'b1;
								ref_pcr_q  <= packet.pcr_value;
								ref_off_q  <= $signed({1'b0, pend_bytes});
							end
						end
						if (pcr_flush) begin
							rate_ticks_q <= (dist_pos && (packet.pcr_value >= ref_pcr_q))
								? (packet.pcr_value - ref_pcr_q) : '0;
							rate_bytes_q <= dist_pos ? byte_span[BYTE_W-1:0] : BYTE_W'(1);
						end
					end
				end
				ST_EMIT: begin
					if (load_ready) begin
						if (last_beat) begin
							pend_q <= '0;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
							pos_q <= pos_q + BYTE_W'(PACKET_BYTES);
						end
					end
				end
				ST_SINGLE: begin
					if (load_ready && upd_ref_q) begin
						have_ref_q <= 1'b1;
						ref_pcr_q  <= cur_pcr_q;
						ref_off_q  <= OFF_AFTER_CUR;
					end
				end
				ST_START, ST_WAIT: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Event payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_pcr_q                  <= packet.pcr_value;
			single_q.arrival_stamp     <= pcr_path ? packet.pcr_value[STAMP_W-1:0] : '0;
			single_q.stamp_valid       <= pcr_path;
			single_q.is_current_packet <= 1'b1;
			single_q.overflow          <= hold_path;
			single_q.last_of_run       <= 1'b1;
		end
		if (div_start) begin
			neg_q <= fneg;
		end
	end

	// Checks
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= CNT_W'(PENDING_DEPTH))
		else $error("pending count above depth");

	a_rate_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rate_bytes_q != '0)
		else $error("zero byte rate");

	a_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_WAIT)
		else $error("divider finished outside wait state");

	a_emit_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> CNT_W'(idx_q) < pend_q)
		else $error("flush index past pending count");

	a_empty_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_drain && (pend_q == '0)) |=> state_q == ST_IDLE)
		else $error("drain with nothing pending left idle");

endmodule

@@ rtl/m2ts_serial_muldiv.sv @@
// Bit-serial multiply then restoring divide: low 30 bits of floor(span * ticks / bytes).
module m2ts_serial_muldiv import m2ts_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [BYTE_W-1:0]  span,
	input  logic [PCR_W-1:0]   rate_ticks,
	input  logic [BYTE_W-1:0]  rate_bytes,
	output logic               done,
	output logic [STAMP_W-1:0] quotient
);

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TOTAL_STEPS - 1);
	localparam logic [STEP_W-1:0] MUL_END   = STEP_W'(MUL_STEPS);

	logic               busy_q;
	logic               done_q;
	logic [STEP_W-1:0]  cnt_q;
	logic [BYTE_W-1:0]  dbits_q;
	logic [PROD_W-1:0]  acc_q;
	logic [BYTE_W-1:0]  rem_q;
	logic [STAMP_W-1:0] quo_q;

	logic [PROD_W-1:0]  mul_sum;
	logic [BYTE_W:0]    trial;
	logic [BYTE_W:0]    trial_sub;
	logic               trial_ge;

	// Multiply phase: MSB-first shift-add over the distance bits
	assign mul_sum = {acc_q[PROD_W-2:0], 1'b0}
		+ (dbits_q[BYTE_W-1] ? PROD_W'(rate_ticks) : '0);

	// Divide phase: one quotient bit per cycle, product shifts out MSB first
	assign trial     = {rem_q, acc_q[PROD_W-1]};
	assign trial_ge  = trial >= {1'b0, rate_bytes};
	assign trial_sub = trial - {1'b0, rate_bytes};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + STEP_W'(1);
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			dbits_q <= span;
			acc_q   <= '0;
			rem_q   <= '0;
		end else if (busy_q) begin
			if (cnt_q < MUL_END) begin
				acc_q   <= mul_sum;
				dbits_q <= {dbits_q[BYTE_W-2:0], 1'b0};
			end else begin
				acc_q <= {acc_q[PROD_W-2:0], 1'b0};
				rem_q <= trial_ge ? trial_sub[BYTE_W-1:0] : trial[BYTE_W-1:0];
				quo_q <= {quo_q[STAMP_W-2:0], trial_ge};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/m2ts_result_reg.sv @@
// One-beat output register between the sequencer and the result channel.
module m2ts_result_reg import m2ts_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load_valid,
	input  m2ts_result_t load_data,
	output logic         load_ready,
	m2ts_out_if.source   result
);

	logic         full_q;
	m2ts_result_t data_q;

	assign load_ready = !full_q || result.ready;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (load_valid && load_ready) begin
			full_q <= 1'b1;
		end else if (result.ready) begin
			full_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			data_q <= load_data;
		end
	end

	assign result.valid             = full_q;
	assign result.arrival_stamp     = data_q.arrival_stamp;
	assign result.stamp_valid       = data_q.stamp_valid;
	assign result.is_current_packet = data_q.is_current_packet;
	assign result.overflow          = data_q.overflow;
	assign result.last_of_run       = data_q.last_of_run;

endmodule

@@ tb/tb_m2ts_arrival_stamp_interpolator.sv @@
// Self-checking testbench for the M2TS arrival stamp interpolator: directed table, then random phases.
module tb_m2ts_arrival_stamp_interpolator;
	import m2ts_pkg::*;

	localparam int PEND_DEPTH     = 63;
	localparam int PKT_LEN        = int'(PACKET_BYTES);
	localparam logic [PCR_W-1:0] PCR_MAX = 42'd2576980377599;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 40;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DIR_ROWS       = 23;

	// Fixed results that can be written down directly
	localparam m2ts_result_t RES_NONE    = '0;
	localparam m2ts_result_t RES_BYPASS  = '{30'd0, 1'b0, 1'b1, 1'b0, 1'b1};
	localparam m2ts_result_t RES_DROPPED = '{30'd0, 1'b0, 1'b1, 1'b1, 1'b1};

	// One row of the directed table; res only counts where res_given is set
	typedef struct packed {
		logic             mode;
		logic             op;
		logic             pcr_on;
		logic [PCR_W-1:0] pcr;
		logic [7:0]       reps;
		logic             res_given;
		m2ts_result_t     res;
	} dir_row_t;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             cfg_wr_en   = 1'b0;
	logic             cfg_wr_data = 1'b0;
	logic             ev_valid    = 1'b0;
	logic             ev_op       = OP_PACKET;
	logic             ev_pcr_on   = 1'b0;
	logic [PCR_W-1:0] ev_pcr      = '0;
	logic             sink_rdy    = 1'b0;

	m2ts_in_if  pkt_if ();
	m2ts_out_if res_if ();

	assign pkt_if.valid       = ev_valid;
	assign pkt_if.operation   = ev_op;
	assign pkt_if.pcr_present = ev_pcr_on;
	assign pkt_if.pcr_value   = ev_pcr;
	assign res_if.ready       = sink_rdy;

	m2ts_arrival_stamp_interpolator #(.PENDING_DEPTH(PEND_DEPTH)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.packet     (pkt_if),
		.result     (res_if)
	);

	// Stamp tracker state
	logic             mdl_mode       = 1'b0;
	logic             mdl_have_ref   = 1'b0;
	logic [PCR_W-1:0] mdl_ref_pcr    = '0;
	int               mdl_ref_off    = 0;
	logic [PCR_W-1:0] mdl_rate_ticks = PCR_W'(1);
	int               mdl_rate_bytes = 1;
	int               mdl_pend       = 0;

	m2ts_result_t stamps_due[$];
	m2ts_result_t step_stamps[$];

	int fail_cnt       = 0;
	int events_sent    = 0;
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int hold_req       = 0;
	int hold_seen      = 0;
	int hold_left      = 0;
	int idle_cycles    = 0;

	// Directed stimulus
	dir_row_t dir_tab [DIR_ROWS] = '{
		// pass-through: extremes of the PCR, drain with no reference
		'{1'b0, OP_PACKET, 1'b1, PCR_MAX,     8'd1,  1'b1, RES_BYPASS},
		'{1'b0, OP_PACKET, 1'b0, 42'd0,       8'd1,  1'b1, RES_BYPASS},
		'{1'b0, OP_DRAIN,  1'b0, 42'd0,       8'd1,  1'b0, RES_NONE},
		// held packets, drain before any reference, first PCR taken as reference
		'{1'b1, OP_PACKET, 1'b0, 42'd0,       8'd2,  1'b0, RES_NONE},
		'{1'b1, OP_DRAIN,  1'b0, 42'd0,       8'd1,  1'b0, RES_NONE},
		'{1'b1, OP_PACKET, 1'b1, 42'd5000,    8'd1,  1'b0, RES_NONE},
		// drain with positions before the reference
		'{1'b1, OP_DRAIN,  1'b0, 42'd0,       8'd1,  1'b0, RES_NONE},
		// new point not after the reference position
		'{1'b1, OP_PACKET, 1'b0, 42'd0,       8'd1,  1'b0, RES_NONE},
		'{1'b1, OP_PACKET, 1'b1, 42'd6000,    8'd1,  1'b0, RES_NONE},
		'{1'b1, OP_PACKET, 1'b1, 42'd6000,    8'd1,  1'b1, '{30'd6000, 1'b1, 1'b1, 1'b0, 1'b1}},
		// repeated PCR leaves pending packets alone
		'{1'b1, OP_PACKET, 1'b0, 42'd0,       8'd2,  1'b0, RES_NONE},
		'{1'b1, OP_PACKET, 1'b1, 42'd6000,    8'd1,  1'b1, '{30'd6000, 1'b1, 1'b1, 1'b0, 1'b1}},
		'{1'b1, OP_PACKET, 1'b1, 42'd33000,   8'd1,  1'b0, RES_NONE},
		// decreasing PCR, then a zero PCR
		'{1'b1, OP_PACKET, 1'b0, 42'd0,       8'd1,  1'b0, RES_NONE},
		'{1'b1, OP_PACKET, 1'b1, 42'd1000,    8'd1,  1'b0, RES_NONE},
		'{1'b1, OP_PACKET, 1'b1, 42'd0,       8'd1,  1'b1, '{30'd0, 1'b1, 1'b1, 1'b0, 1'b1}},
		// fill the pending store, drop one, flush the lot with the largest PCR
		'{1'b1, OP_PACKET, 1'b0, 42'd0,       8'd63, 1'b0, RES_NONE},
		'{1'b1, OP_PACKET, 1'b0, 42'd0,       8'd1,  1'b1, RES_DROPPED},
		'{1'b1, OP_PACKET, 1'b1, PCR_MAX,     8'd1,  1'b0, RES_NONE},
		// pending packets survive a mode switch and drain in pass-through mode
		'{1'b1, OP_PACKET, 1'b0, 42'd0,       8'd2,  1'b0, RES_NONE},
		'{1'b0, OP_DRAIN,  1'b0, 42'd0,       8'd1,  1'b0, RES_NONE},
		'{1'b0, OP_PACKET, 1'b1, 42'd77,      8'd1,  1'b1, RES_BYPASS},
		'{1'b1, OP_PACKET, 1'b1, PCR_MAX,     8'd1,  1'b1, '{30'h3FFFFFFF, 1'b1, 1'b1, 1'b0, 1'b1}}
	};

	always #6 clk = ~clk;

	function automatic m2ts_result_t mk_res(logic [STAMP_W-1:0] stamp, logic sv, logic cur,
			logic ovf);
		return '{arrival_stamp: stamp, stamp_valid: sv, is_current_packet: cur, overflow: ovf,
			last_of_run: 1'b0};
	endfunction

	// Interpolate every pending packet, oldest first, at the current rate
	function automatic void flush_pending_stamps();
		logic [63:0] den, d, q;
		int pos;
		den = 64'(mdl_rate_bytes);
		for (int i = 0; i < mdl_pend; i++) begin
			pos = i * PKT_LEN;
			if (pos >= mdl_ref_off) begin
				d = 64'(pos - mdl_ref_off);
				q = 64'(mdl_ref_pcr) + (d * 64'(mdl_rate_ticks)) / den;
			end else begin
				d = 64'(mdl_ref_off - pos);
				q = 64'(mdl_ref_pcr) - (d * 64'(mdl_rate_ticks)) / den;
			end
			step_stamps.push_back(mk_res(q[STAMP_W-1:0], 1'b1, 1'b0, 1'b0));
		end
		mdl_pend = 0;
	endfunction

	// Results caused by one accepted event; updates the tracker state
	function automatic void predict_stamps(logic op, logic pcr_on, logic [PCR_W-1:0] pcr);
		int span;
		m2ts_result_t r;
		step_stamps.delete();
		if (op == OP_DRAIN) begin
			if (mdl_have_ref && mdl_pend > 0)
				flush_pending_stamps();
		end else if (!mdl_mode) begin
			step_stamps.push_back(mk_res('0, 1'b0, 1'b1, 1'b0));
		end else if (!pcr_on || (!mdl_have_ref && mdl_pend > 0)) begin
			if (mdl_pend >= PEND_DEPTH) begin
				step_stamps.push_back(mk_res('0, 1'b0, 1'b1, 1'b1));
			end else begin
				if (pcr_on) begin
					mdl_have_ref = 1'b1;
					mdl_ref_pcr  = pcr;
					mdl_ref_off  = mdl_pend * PKT_LEN;
				end
				mdl_pend++;
			end
		end else begin
			if (mdl_pend > 0 && pcr != mdl_ref_pcr) begin
				span = mdl_pend * PKT_LEN - mdl_ref_off;
				mdl_rate_ticks = (span > 0 && pcr >= mdl_ref_pcr) ? pcr - mdl_ref_pcr : '0;
				mdl_rate_bytes = (span > 0) ? span : 1;
				flush_pending_stamps();
			end
			step_stamps.push_back(mk_res(pcr[STAMP_W-1:0], 1'b1, 1'b1, 1'b0));
			if (!mdl_have_ref || pcr != mdl_ref_pcr) begin
				mdl_have_ref = 1'b1;
				mdl_ref_pcr  = pcr;
				mdl_ref_off  = -PKT_LEN;
			end
		end
		if (step_stamps.size() > 0) begin
			r = step_stamps.pop_back();
			r.last_of_run = 1'b1;
			step_stamps.push_back(r);
		end
	endfunction

	function automatic logic [PCR_W-1:0] rand_pcr();
		logic [PCR_W-1:0] v;
		v = PCR_W'({$urandom, $urandom});
		if (v > PCR_MAX)
			v = v - PCR_MAX - PCR_W'(1);
		return v;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_cnt++;
		end
	endfunction

	// Offer one event after a random gap and book its results once accepted
	task automatic send_event(input logic op, input logic pcr_on, input logic [PCR_W-1:0] pcr,
			input logic res_given = 1'b0, input m2ts_result_t given = '0);
		while ($urandom_range(99) < src_idle_pct) begin
			ev_valid <= 1'b0;
			@(posedge clk);
		end
		ev_valid  <= 1'b1;
		ev_op     <= op;
		ev_pcr_on <= pcr_on;
		ev_pcr    <= pcr;
		do @(posedge clk); while (!pkt_if.ready);
		events_sent++;
		predict_stamps(op, pcr_on, pcr);
		if (res_given)
			stamps_due.push_back(given);
		else
			foreach (step_stamps[k]) stamps_due.push_back(step_stamps[k]);
	endtask

	// Mode write only once the block has gone quiet
	task automatic set_mode(input logic m);
		ev_valid <= 1'b0;
		while (stamps_due.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mdl_mode = m;
	endtask

	// Result side: random stalls plus one long hold-off on request
	always @(posedge clk) begin : sink_pace
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			sink_rdy <= 1'b0;
		end else begin
			sink_rdy <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Compare each result beat with the oldest booked stamp
	always @(posedge clk) begin : result_check
		m2ts_result_t want;
		if (arst_n && res_if.valid && sink_rdy) begin
			if (stamps_due.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual stamp %0h",
					$time, res_if.arrival_stamp);
				fail_cnt++;
			end else begin
				want = stamps_due.pop_front();
				check_field("arrival_stamp", 32'(want.arrival_stamp), 32'(res_if.arrival_stamp));
				check_field("stamp_valid", 32'(want.stamp_valid), 32'(res_if.stamp_valid));
				check_field("is_current_packet", 32'(want.is_current_packet),
					32'(res_if.is_current_packet));
				check_field("overflow", 32'(want.overflow), 32'(res_if.overflow));
				check_field("last_of_run", 32'(want.last_of_run), 32'(res_if.last_of_run));
			end
		end
	end

	// Watchdog: no beat on either channel for too long
	always @(posedge clk) begin
		if ((ev_valid && pkt_if.ready) || (res_if.valid && sink_rdy)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d stamps still due", $time, stamps_due.size());
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int held, kind, phase_end;
		logic [PCR_W-1:0] stream_pcr, step;
		stream_pcr = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		set_mode(1'b0);

		// directed table
		foreach (dir_tab[r]) begin
			if (dir_tab[r].mode != mdl_mode)
				set_mode(dir_tab[r].mode);
			repeat (dir_tab[r].reps)
				send_event(dir_tab[r].op, dir_tab[r].pcr_on, dir_tab[r].pcr,
					dir_tab[r].res_given, dir_tab[r].res);
		end
		stream_pcr = mdl_ref_pcr;

		// random phases
		for (int ph = 0; ph < PHASES; ph++) begin
			set_mode((ph == 2 || ph == 5) ? 1'b0 : 1'b1);
			case (ph % 4)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct <= 0;
				end
				1: begin
					src_idle_pct = 65;
					sink_stall_pct <= 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct <= 65;
				end
				default: begin
					src_idle_pct = 34;
					sink_stall_pct <= 34;
				end
			endcase
			// long hold-off on the result side while events keep coming
			if (ph == 4)
				hold_req <= hold_req + 1;
			phase_end = events_sent + PHASE_ITEMS;
			while (events_sent < phase_end) begin
				kind = $urandom_range(99);
				if (kind < 68) begin
					// held packets closed by an advancing PCR
					held = ($urandom_range(15) == 0) ? $urandom_range(70, 40) : $urandom_range(6);
					repeat (held) send_event(OP_PACKET, 1'b0, rand_pcr());
					step = ($urandom_range(9) == 0) ? rand_pcr() >> $urandom_range(24)
						: PCR_W'($urandom_range(400000));
					stream_pcr = (stream_pcr > PCR_MAX - step) ? step : stream_pcr + step;
					send_event(OP_PACKET, 1'b1, stream_pcr);
				end else if (kind < 78) begin
					send_event(OP_DRAIN, 1'($urandom_range(1)), rand_pcr());
				end else if (kind < 86) begin
					// reference PCR seen again
					repeat ($urandom_range(3)) send_event(OP_PACKET, 1'b0, rand_pcr());
					send_event(OP_PACKET, 1'b1, mdl_ref_pcr);
				end else if (kind < 93) begin
					// PCR steps backwards
					repeat ($urandom_range(4, 1)) send_event(OP_PACKET, 1'b0, rand_pcr());
					step = PCR_W'($urandom_range(500000, 1));
					stream_pcr = (stream_pcr > step) ? stream_pcr - step : '0;
					send_event(OP_PACKET, 1'b1, stream_pcr);
				end else begin
					send_event(1'($urandom_range(1)), 1'($urandom_range(1)), rand_pcr());
				end
			end
		end

		// let everything drain out
		ev_valid <= 1'b0;
		while (stamps_due.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES * 4) @(posedge clk);
		if (fail_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ files.f @@
rtl/m2ts_pkg.sv
rtl/m2ts_in_if.sv
rtl/m2ts_out_if.sv
rtl/m2ts_serial_muldiv.sv
rtl/m2ts_result_reg.sv
rtl/m2ts_arrival_stamp_interpolator.sv
tb/tb_m2ts_arrival_stamp_interpolator.sv
